// ===== rtl/core/hsdir_ring_successor_lookup_defines.svh =====
// ----------------------------------------------------------------------------
// hsdir_ring_successor_lookup_defines.svh
// Assertion macros for the directory ring lookup block.
// ----------------------------------------------------------------------------
`ifndef HSDIR_RING_SUCCESSOR_LOOKUP_DEFINES_SVH
`define HSDIR_RING_SUCCESSOR_LOOKUP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset.
`define HRSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define HRSL_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define HRSL_ASSERT(lbl, prop, msg)
`define HRSL_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== rtl/core/hrsl_pkg.sv =====
// ----------------------------------------------------------------------------
// hrsl_pkg
// Shared codes and controller/datapath interface types of the ring lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package hrsl_pkg;

	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int PREFIX_W  = 32;
	localparam int IDX_OUT_W = 10;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FEW  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} ctl_state_t;

	// accepted item, decoded at the top level
	typedef struct packed {
		logic accept;
		logic is_query;
	} req_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic scan_issue;
		logic finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic count_zero;
		logic scan_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/hsdir_ring_successor_lookup.sv =====
// ----------------------------------------------------------------------------
// hsdir_ring_successor_lookup
// Directory ring successor lookup: clear, append and query over a sorted table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Clear, append and the
// unused command code answer in the next cycle and leave busy low, so a new
// item can follow at once. A query scans the table in a single pass, one
// memory read per cycle, keeps busy high through the scan, drain and finish
// states and answers from the done register after finish; an empty table
// answers in the next cycle. Every result is shown for exactly one cycle with
// done high and must be taken then: there is no way to stall it.
`default_nettype none

module hsdir_ring_successor_lookup #(
	parameter int MAX_ENTRIES = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [hrsl_pkg::CMD_W-1:0]       command,
	input  wire logic [hrsl_pkg::PREFIX_W-1:0]    entry_prefix,
	input  wire logic                             entry_is_dir,
	input  wire logic [hrsl_pkg::PREFIX_W-1:0]    search_key,
	output logic                                  done,
	output logic [hrsl_pkg::STATUS_W-1:0]         status,
	output logic [hrsl_pkg::IDX_OUT_W-1:0]        first_index,
	output logic [hrsl_pkg::IDX_OUT_W-1:0]        second_index,
	output logic [hrsl_pkg::IDX_OUT_W-1:0]        third_index
);
	import hrsl_pkg::*;

	req_t     req;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign req.accept   = start && !busy;
	assign req.is_query = (command == CMD_QUERY);

	hrsl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	hrsl_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.command      (command),
		.entry_prefix (entry_prefix),
		.entry_is_dir (entry_is_dir),
		.search_key   (search_key),
		.done         (done),
		.status       (status),
		.first_index  (first_index),
		.second_index (second_index),
		.third_index  (third_index)
	);

endmodule

`default_nettype wire

// ===== rtl/core/hrsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// hrsl_ctrl
// Sequencer for the query scan: issue reads, drain, finish.
// ----------------------------------------------------------------------------
`default_nettype none

module hrsl_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hrsl_pkg::req_t     req,
	input  wire hrsl_pkg::dp_stat_t stat,
	output hrsl_pkg::dp_cmd_t       cmd,
	output logic                    busy
);
	import hrsl_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.accept && req.is_query && !stat.count_zero) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy           = 1'b1;
		cmd.accept     = 1'b0;
		cmd.scan_issue = 1'b0;
		cmd.finish     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy       = 1'b0;
				cmd.accept = req.accept;
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
			end
			S_DRAIN: begin
				busy = 1'b1;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/hrsl_datapath.sv =====
// ----------------------------------------------------------------------------
// hrsl_datapath
// Entry memory, entry count, single-pass successor tracking and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsdir_ring_successor_lookup_defines.svh"

module hrsl_datapath #(
	parameter int MAX_ENTRIES = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire hrsl_pkg::dp_cmd_t                cmd,
	output hrsl_pkg::dp_stat_t                    stat,
	input  wire logic [hrsl_pkg::CMD_W-1:0]       command,
	input  wire logic [hrsl_pkg::PREFIX_W-1:0]    entry_prefix,
	input  wire logic                             entry_is_dir,
	input  wire logic [hrsl_pkg::PREFIX_W-1:0]    search_key,
	output logic                                  done,
	output logic [hrsl_pkg::STATUS_W-1:0]         status,
	output logic [hrsl_pkg::IDX_OUT_W-1:0]        first_index,
	output logic [hrsl_pkg::IDX_OUT_W-1:0]        second_index,
	output logic [hrsl_pkg::IDX_OUT_W-1:0]        third_index
);
	import hrsl_pkg::*;

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int OW = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;
	localparam int MW = PREFIX_W + 1;

	// entry memory: {dir flag, prefix}
	logic [MW-1:0] mem [MAX_ENTRIES];

	logic [CW-1:0]       count_q;
	logic [IW-1:0]       scan_q;
	logic [PREFIX_W-1:0] key_q;
	logic [CMD_W-1:0]    op_q;

	logic [MW-1:0] rdata_s1;
	logic [IW-1:0] idx_s1;
	logic          valid_s1;

	// first three flagged entries, match, and up to two flagged after the match
	logic [1:0]    flag_cnt_q;
	logic [IW-1:0] f0_q, f1_q, f2_q;
	logic          found_q;
	logic [IW-1:0] a_q;
	logic [1:0]    after_cnt_q;
	logic [IW-1:0] n1_q, n2_q;

	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_OUT_W-1:0] first_q, second_q, third_q;

	// accept-time decode
	logic                imm_done;
	logic [STATUS_W-1:0] imm_status;
	logic                mem_we;
	logic                count_clr;
	logic                scan_init;
	logic                is_full;

	logic [STATUS_W-1:0] fin_status;
	logic [IW-1:0]       fin_a, fin_b, fin_c;
	logic [OW-1:0]       fin_a_w, fin_b_w, fin_c_w;

	logic hit;

	assign is_full         = (count_q == CW'(MAX_ENTRIES));
	assign stat.count_zero = (count_q == '0);
	assign stat.scan_last  = (CW'(scan_q) == (count_q - CW'(1)));

	always_comb begin
		imm_done   = 1'b0;
		imm_status = STAT_OK;
		mem_we     = 1'b0;
		count_clr  = 1'b0;
		scan_init  = 1'b0;
		if (cmd.accept) begin
			unique case (command)
				CMD_CLEAR: begin
					imm_done  = 1'b1;
					count_clr = 1'b1;
				end
				CMD_APPEND: begin
					imm_done = 1'b1;
					if (is_full) begin
						imm_status = STAT_FULL;
					end else begin
						mem_we = 1'b1;
					end
				end
				CMD_QUERY: begin
					if (count_q == '0) begin
						imm_done   = 1'b1;
						imm_status = STAT_FEW;
					end else begin
						scan_init = 1'b1;
					end
				end
				default: begin
					imm_done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IW-1:0]] <= {entry_is_dir, entry_prefix};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_issue) begin
			rdata_s1 <= mem[scan_q];
			idx_s1   <= scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			scan_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_issue;
			if (count_clr) begin
				count_q <= '0;
			end else if (mem_we) begin
				count_q <= count_q + CW'(1);
			end
			if (scan_init) begin
				scan_q <= '0;
			end else if (cmd.scan_issue) begin
				scan_q <= scan_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= search_key;
			op_q  <= command;
		end
	end

	assign hit = valid_s1 && rdata_s1[PREFIX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_cnt_q  <= '0;
			found_q     <= 1'b0;
			after_cnt_q <= '0;
		end else if (scan_init) begin
			flag_cnt_q  <= '0;
			found_q     <= 1'b0;
			after_cnt_q <= '0;
		end else if (hit) begin
			if (flag_cnt_q != 2'd3) begin
				flag_cnt_q <= flag_cnt_q + 2'd1;
			end
			if (found_q) begin
				if (after_cnt_q != 2'd2) begin
					after_cnt_q <= after_cnt_q + 2'd1;
				end
			end else if (rdata_s1[PREFIX_W-1:0] > key_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			case (flag_cnt_q)
				2'd0:    f0_q <= idx_s1;
				2'd1:    f1_q <= idx_s1;
				2'd2:    f2_q <= idx_s1;
				default: ;
			endcase
			if (found_q) begin
				case (after_cnt_q)
					2'd0:    n1_q <= idx_s1;
					2'd1:    n2_q <= idx_s1;
					default: ;
				endcase
			end else if (rdata_s1[PREFIX_W-1:0] > key_q) begin
				a_q <= idx_s1;
			end
		end
	end

	// successors wrap to the start of the ring when the pass ran out
	always_comb begin
		fin_status = STAT_OK;
		fin_a      = '0;
		fin_b      = '0;
		fin_c      = '0;
		if (flag_cnt_q != 2'd3) begin
			fin_status = STAT_FEW;
		end else if (!found_q) begin
			fin_a = f0_q;
			fin_b = f1_q;
			fin_c = f2_q;
		end else begin
			fin_a = a_q;
			case (after_cnt_q)
				2'd0: begin
					fin_b = f0_q;
					fin_c = f1_q;
				end
				2'd1: begin
					fin_b = n1_q;
					fin_c = f0_q;
				end
				default: begin
					fin_b = n1_q;
					fin_c = n2_q;
				end
			endcase
		end
	end

	assign fin_a_w = OW'(fin_a);
	assign fin_b_w = OW'(fin_b);
	assign fin_c_w = OW'(fin_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= imm_done || cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= fin_status;
			first_q  <= fin_a_w[IDX_OUT_W-1:0];
			second_q <= fin_b_w[IDX_OUT_W-1:0];
			third_q  <= fin_c_w[IDX_OUT_W-1:0];
		end else if (imm_done) begin
			status_q <= imm_status;
			first_q  <= '0;
			second_q <= '0;
			third_q  <= '0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign first_index  = first_q;
	assign second_index = second_q;
	assign third_index  = third_q;

	`HRSL_ASSERT_NEVER(a_count_bound, count_q > CW'(MAX_ENTRIES), "entry count above capacity")

	`HRSL_ASSERT_NEVER(a_scan_past_count, valid_s1 && (CW'(idx_s1) >= count_q), "read beyond entry count")

	`HRSL_ASSERT(a_query_distinct, done_q && op_q == CMD_QUERY && status_q == STAT_OK |-> first_q != second_q && second_q != third_q && first_q != third_q, "query result indices not distinct")

	`HRSL_ASSERT(a_clear_empties, done_q && op_q == CMD_CLEAR |-> count_q == '0 && status_q == STAT_OK, "clear left entries")

endmodule

`default_nettype wire

// ===== verif/hsdir_ring_successor_lookup_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsdir_ring_successor_lookup_checker
// Watches the item and result ports of the ring lookup, keeps its own copy of
// the entry table, predicts every answer and compares it with what comes out.
// ----------------------------------------------------------------------------

module hsdir_ring_successor_lookup_checker #(
	parameter int MAX_ENTRIES = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic                             busy,
	input  wire logic [hrsl_pkg::CMD_W-1:0]       command,
	input  wire logic [hrsl_pkg::PREFIX_W-1:0]    entry_prefix,
	input  wire logic                             entry_is_dir,
	input  wire logic [hrsl_pkg::PREFIX_W-1:0]    search_key,
	input  wire logic                             done,
	input  wire logic [hrsl_pkg::STATUS_W-1:0]    status,
	input  wire logic [hrsl_pkg::IDX_OUT_W-1:0]   first_index,
	input  wire logic [hrsl_pkg::IDX_OUT_W-1:0]   second_index,
	input  wire logic [hrsl_pkg::IDX_OUT_W-1:0]   third_index,
	output int                                    mismatch_count,
	output int                                    pending_results
);

	import hrsl_pkg::*;

	localparam int DIRS_NEEDED = 3;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [IDX_OUT_W-1:0] first;
		logic [IDX_OUT_W-1:0] second;
		logic [IDX_OUT_W-1:0] third;
	} lookup_result_t;

	logic [PREFIX_W-1:0] ring_prefix [MAX_ENTRIES];
	logic                ring_is_dir [MAX_ENTRIES];
	int                  ring_count;
	lookup_result_t      lookup_q [$];

	// next flagged slot after pos, walking the used part of the ring
	function automatic int next_dir_after(input int pos);
		int j;
		j = pos;
		for (int k = 0; k < ring_count; k++) begin
			j = (j + 1 >= ring_count) ? 0 : j + 1;
			if (ring_is_dir[j])
				return j;
		end
		return pos;
	endfunction

	function automatic lookup_result_t apply_item(
		input logic [CMD_W-1:0]    cmd,
		input logic [PREFIX_W-1:0] pfx,
		input logic                dir,
		input logic [PREFIX_W-1:0] key
	);
		lookup_result_t r;
		int             dir_total;
		int             first_dir;
		int             hit;
		int             second_hit;
		bit             found;
		r = '0;
		case (cmd)
			CMD_CLEAR: begin
				ring_count = 0;
			end
			CMD_APPEND: begin
				if (ring_count >= MAX_ENTRIES) begin
					r.status = STAT_FULL;
				end else begin
					ring_prefix[ring_count] = pfx;
					ring_is_dir[ring_count] = dir;
					ring_count++;
				end
			end
			CMD_QUERY: begin
				dir_total = 0;
				first_dir = -1;
				hit = 0;
				found = 1'b0;
				for (int i = 0; i < ring_count; i++) begin
					if (ring_is_dir[i]) begin
						dir_total++;
						if (first_dir < 0)
							first_dir = i;
						if (!found && ring_prefix[i] > key) begin
							found = 1'b1;
							hit = i;
						end
					end
				end
				if (dir_total < DIRS_NEEDED) begin
					r.status = STAT_FEW;
				end else begin
					// no prefix above the key: wrap to the first flagged entry
					if (!found)
						hit = first_dir;
					second_hit = next_dir_after(hit);
					r.status = STAT_OK;
					r.first  = IDX_OUT_W'(hit);
					r.second = IDX_OUT_W'(second_hit);
					r.third  = IDX_OUT_W'(next_dir_after(second_hit));
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic log_mismatch(input string what, input lookup_result_t want,
		input lookup_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: expected status %0d idx %0d/%0d/%0d, got status %0d idx %0d/%0d/%0d",
				$realtime, what, want.status, want.first, want.second, want.third,
				got.status, got.first, got.second, got.third);
	endtask

	// result first, then the new item: a result never belongs to an item
	// accepted at the same edge
	always @(posedge clk) begin : watch
		lookup_result_t got;
		lookup_result_t want;
		if (arst_n) begin
			if (done) begin
				got = {status, first_index, second_index, third_index};
				if (lookup_q.size() == 0) begin
					log_mismatch("result with nothing expected", '0, got);
				end else begin
					want = lookup_q.pop_front();
					if (got !== want)
						log_mismatch("result mismatch", want, got);
				end
			end
			if (start && !busy)
				lookup_q.push_back(apply_item(command, entry_prefix, entry_is_dir, search_key));
			pending_results = lookup_q.size();
		end
	end

endmodule

// ===== verif/hsdir_ring_successor_lookup_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsdir_ring_successor_lookup_tb
// Drives clear, append, query and unused-code items into the ring lookup: a directed set
// of corner cases, then random load-and-query episodes.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module hsdir_ring_successor_lookup_tb;

	import hrsl_pkg::*;

	localparam int MAX_ENTRIES  = 1024;
	localparam int RANDOM_ITEMS = 265;
	localparam int LIMIT_CYCLES = 1000000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [CMD_W-1:0]     command;
	logic [PREFIX_W-1:0]  entry_prefix;
	logic                 entry_is_dir;
	logic [PREFIX_W-1:0]  search_key;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [IDX_OUT_W-1:0] first_index;
	logic [IDX_OUT_W-1:0] second_index;
	logic [IDX_OUT_W-1:0] third_index;

	int mismatch_count;
	int pending_results;
	int cycle_count = 0;
	int items_sent  = 0;
	bit idle_on     = 1'b1;

	// prefixes loaded since the last clear, used to aim query keys
	logic [PREFIX_W-1:0] loaded [$];

	always #4 clk = ~clk;

	hsdir_ring_successor_lookup #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.entry_prefix (entry_prefix),
		.entry_is_dir (entry_is_dir),
		.search_key   (search_key),
		.done         (done),
		.status       (status),
		.first_index  (first_index),
		.second_index (second_index),
		.third_index  (third_index)
	);

	hsdir_ring_successor_lookup_checker #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.entry_prefix    (entry_prefix),
		.entry_is_dir    (entry_is_dir),
		.search_key      (search_key),
		.done            (done),
		.status          (status),
		.first_index     (first_index),
		.second_index    (second_index),
		.third_index     (third_index),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// returns at the edge where the item was taken; start stays high so the
	// next item can follow without a gap
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PREFIX_W-1:0] pfx,
		input logic dir, input logic [PREFIX_W-1:0] key);
		int gap;
		if (idle_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		command      <= cmd;
		entry_prefix <= pfx;
		entry_is_dir <= dir;
		search_key   <= key;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	task automatic clear_table();
		send_item(CMD_CLEAR, $urandom(), $urandom_range(0, 1), $urandom());
		loaded.delete();
	endtask

	task automatic append_entry(input logic [PREFIX_W-1:0] pfx, input logic dir);
		send_item(CMD_APPEND, pfx, dir, $urandom());
		if (loaded.size() < MAX_ENTRIES)
			loaded.push_back(pfx);
	endtask

	task automatic query_key(input logic [PREFIX_W-1:0] key);
		send_item(CMD_QUERY, $urandom(), $urandom_range(0, 1), key);
	endtask

	// keys on, just below and just above stored prefixes, plus the extremes and random keys
	function automatic logic [PREFIX_W-1:0] pick_key();
		logic [PREFIX_W-1:0] p;
		if (loaded.size() == 0)
			return $urandom();
		p = loaded[$urandom_range(0, loaded.size() - 1)];
		case ($urandom_range(0, 5))
			0: return p;
			1: return p - 1;
			2: return p + 1;
			3: return '0;
			4: return '1;
			default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		int                  n_entries;
		int                  n_queries;
		int                  dir_odds;
		int                  random_base;
		bit                  sorted;
		logic [PREFIX_W-1:0] cur;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		command      <= CMD_CLEAR;
		entry_prefix <= '0;
		entry_is_dir <= 1'b0;
		search_key   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		clear_table();
		query_key('0);
		append_entry('0, 1'b1);
		append_entry(32'h0000_0010, 1'b0);
		append_entry(32'h8000_0000, 1'b1);
		query_key(32'h0000_0001);
		append_entry('1, 1'b1);
		query_key('0);
		query_key('1);
		query_key(32'h7FFF_FFFF);
		query_key(32'hFFFF_FFFE);
		send_item(CMD_UNUSED, '1, 1'b1, '1);
		append_entry('1, 1'b0);
		query_key(32'h8000_0000);
		send_item(CMD_CLEAR, '1, 1'b1, '1);
		loaded.delete();
		query_key('1);
		append_entry(32'h1234_5678, 1'b1);
		append_entry(32'h1234_5678, 1'b1);
		append_entry(32'h1234_5678, 1'b1);
		query_key(32'h1234_5678);
		query_key(32'h1234_5677);
		clear_table();

		// random load-and-query episodes, mostly sorted loads
		random_base = items_sent;
		while (items_sent - random_base < RANDOM_ITEMS) begin
			if (items_sent - random_base > RANDOM_ITEMS - 40)
				idle_on = 1'b0;
			else
				idle_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) < 8 || loaded.size() > 200)
				clear_table();
			n_entries = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120)
				: $urandom_range(0, 12);
			dir_odds = ($urandom_range(0, 3) == 0) ? 1 : 3;
			sorted = ($urandom_range(0, 4) != 0);
			cur = $urandom_range(0, 32'h0FFF_FFFF);
			for (int i = 0; i < n_entries; i++) begin
				if ($urandom_range(0, 14) == 0) begin
					if ($urandom_range(0, 1))
						query_key(pick_key());
					else
						send_item(CMD_UNUSED, $urandom(), $urandom_range(0, 1), $urandom());
				end
				if (sorted) begin
					if ($urandom_range(0, 7) != 0)
						cur = cur + $urandom_range(1, 32'h0FFF_FFFF);
					append_entry(cur, $urandom_range(0, 3) < dir_odds);
				end else begin
					append_entry($urandom(), $urandom_range(0, 3) < dir_odds);
				end
			end
			n_queries = $urandom_range(1, 6);
			for (int q = 0; q < n_queries; q++)
				query_key(pick_key());
		end
		start <= 1'b0;

		do @(negedge clk); while (pending_results != 0);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hrsl_pkg.sv
rtl/core/hrsl_ctrl.sv
rtl/core/hrsl_datapath.sv
rtl/core/hsdir_ring_successor_lookup.sv
verif/hsdir_ring_successor_lookup_checker.sv
verif/hsdir_ring_successor_lookup_tb.sv
